>>> hw/rtl/text_console_glyph_renderer_assert.svh
// assertion macros for the checker of the glyph renderer
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TCGR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TCGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tcgr_pkg.sv
package tcgr_pkg;

  localparam int GLYPH_ROWS_DEF  = 16;
  localparam int GLYPH_COUNT_DEF = 128;
  localparam int GLYPH_COLS      = 8;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int DIM_W   = 9;
  localparam int CURS_W  = 8;
  localparam int PX_W    = 11;
  localparam int PY_W    = 12;
  localparam int COLOR_W = 32;

  localparam logic [IN_TUSER_W-1:0] FUNC_PUT  = 2'd0;
  localparam logic [IN_TUSER_W-1:0] FUNC_LOAD = 2'd1;
  localparam logic [IN_TUSER_W-1:0] FUNC_HOME = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FG      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BG      = 2'd3;

  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_NL  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  localparam logic [DIM_W-1:0]   COLUMNS_RESET = 9'd80;
  localparam logic [DIM_W-1:0]   ROWS_RESET    = 9'd25;
  localparam logic [DIM_W-1:0]   DIM_MAX       = 9'd256;
  localparam logic [COLOR_W-1:0] FG_RESET      = 32'h00FF_FFFF;
  localparam logic [COLOR_W-1:0] BG_RESET      = 32'h0000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DRAIN
  } state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

>>> hw/rtl/tcgr_ram.sv
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata <= mem_r[raddr];
  end

endmodule

>>> hw/rtl/text_console_glyph_renderer.sv
// Text console glyph renderer. Words on in_* carry console commands (tuser: put
// character, load font byte, home cursor); the block keeps the cursor and a
// font store of GLYPH_COUNT glyphs of GLYPH_ROWS rows, loaded one byte per word.
// A printable code yields GLYPH_ROWS output words, one per glyph row, top row
// first, with tlast on the bottom row. Control words, font loads and codes with
// no glyph leave the block ready for the next word. A drawn glyph keeps
// in_tready low until its last row is loaded for output: the single read port of
// the font store delivers one row per cycle while the output is not stalled, and
// its read data is registered. The font store has no reset; a glyph must be
// loaded before it is drawn. Configuration writes are for idle periods only.
module text_console_glyph_renderer #(
  parameter int GLYPH_ROWS  = tcgr_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // char_code, font_addr, font_byte, zero pad
  input  logic [tcgr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic [tcgr_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pixel_x, pixel_y, row_bits, fore_color, back_color, zero pad
  output logic [tcgr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [tcgr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int STORE = GLYPH_COUNT * GLYPH_ROWS;
  localparam int AW    = $clog2(STORE);
  localparam int PYW   = $clog2(GLYPH_ROWS);
  localparam logic [AW-1:0]  ROWS_A   = AW'(GLYPH_ROWS);
  localparam logic [tcgr_pkg::PY_W-1:0] ROWS_Y = tcgr_pkg::PY_W'(GLYPH_ROWS);
  localparam logic [PYW-1:0] LAST_ROW = PYW'(GLYPH_ROWS - 1);
  localparam logic [8:0]     COUNT_C  = 9'(GLYPH_COUNT);

  tcgr_pkg::state_t state_r, state_nxt;

  logic [tcgr_pkg::DIM_W-1:0]   columns_r, rows_r;
  logic [tcgr_pkg::COLOR_W-1:0] fg_r, bg_r;
  logic [tcgr_pkg::CURS_W-1:0]  col_r, row_r, col_nxt, row_nxt;

  logic [AW-1:0]               glyph_base_r;
  logic [tcgr_pkg::PY_W-1:0]   base_y_r;
  logic [tcgr_pkg::PX_W-1:0]   base_x_r;
  logic [PYW-1:0]              rd_py_r, rd_py_nxt;
  logic [PYW-1:0]              rd_row_r;
  logic                        rd_valid_r, rd_valid_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_last_r;
  logic [tcgr_pkg::PX_W-1:0]   out_px_r;
  logic [tcgr_pkg::PY_W-1:0]   out_py_r;
  logic [7:0]                  out_bits_r;
  logic [tcgr_pkg::COLOR_W-1:0] out_fg_r, out_bg_r;

  logic                        accept, draw, load, out_free, ram_re, ram_we;
  logic [7:0]                  code, font_byte, ram_rdata;
  logic [10:0]                 font_addr;
  logic [tcgr_pkg::DIM_W-1:0]  cols_c, rows_c;
  logic [8:0]                  col_t, row_t;

  assign code      = in_tdata[7:0];
  assign font_addr = in_tdata[18:8];
  assign font_byte = in_tdata[26:19];
  assign accept    = in_tvalid & in_tready;
  assign cols_c    = tcgr_pkg::clamp_dim(columns_r);
  assign rows_c    = tcgr_pkg::clamp_dim(rows_r);
  assign out_free  = ~out_valid_r | out_tready;
  assign load      = rd_valid_r & out_free;
  assign ram_we    = accept & (in_tuser == tcgr_pkg::FUNC_LOAD) & (32'(font_addr) < STORE);

  // cursor update for put character and home cursor
  always_comb begin
    draw  = 1'b0;
    col_t = {1'b0, col_r};
    row_t = {1'b0, row_r};
    priority if (code == tcgr_pkg::CHAR_NL) begin
      col_t = '0;
      row_t = row_t + 9'd1;
    end else if (code == tcgr_pkg::CHAR_CR) begin
      col_t = '0;
    end else if (code == tcgr_pkg::CHAR_TAB) begin
      col_t = (col_t + 9'd4) & ~9'd3;
    end else begin
      draw  = ({1'b0, code} < COUNT_C);
      col_t = col_t + 9'd1;
    end
    if (col_t >= cols_c) begin
      col_t = '0;
      row_t = row_t + 9'd1;
    end
    if (row_t >= rows_c) row_t = rows_c - 9'd1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      unique case (in_tuser)
        tcgr_pkg::FUNC_PUT: begin
          col_nxt = col_t[7:0];
          row_nxt = row_t[7:0];
        end
        tcgr_pkg::FUNC_HOME: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcgr_pkg::ST_IDLE:
        if (accept && in_tuser == tcgr_pkg::FUNC_PUT && draw) state_nxt = tcgr_pkg::ST_DRAW;
      tcgr_pkg::ST_DRAW:
        if (ram_re && rd_py_r == LAST_ROW) state_nxt = tcgr_pkg::ST_DRAIN;
      tcgr_pkg::ST_DRAIN:
        if (load) state_nxt = tcgr_pkg::ST_IDLE;
      default: state_nxt = tcgr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = (state_r == tcgr_pkg::ST_IDLE);
    ram_re    = (state_r == tcgr_pkg::ST_DRAW) & (~rd_valid_r | load);
  end

  always_comb begin
    rd_py_nxt = rd_py_r;
    if (accept) rd_py_nxt = '0;
    else if (ram_re) rd_py_nxt = rd_py_r + PYW'(1);
    rd_valid_nxt = ram_re ? 1'b1 : (load ? 1'b0 : rd_valid_r);
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  tcgr_ram #(
    .WIDTH (8),
    .DEPTH (STORE)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(font_addr)),
    .wdata (font_byte),
    .re    (ram_re),
    .raddr (glyph_base_r + AW'(rd_py_r)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcgr_pkg::ST_IDLE;
      columns_r   <= tcgr_pkg::COLUMNS_RESET;
      rows_r      <= tcgr_pkg::ROWS_RESET;
      fg_r        <= tcgr_pkg::FG_RESET;
      bg_r        <= tcgr_pkg::BG_RESET;
      col_r       <= '0;
      row_r       <= '0;
      rd_py_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      rd_py_r     <= rd_py_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          tcgr_pkg::REG_COLUMNS: columns_r <= cfg_wdata[tcgr_pkg::DIM_W-1:0];
          tcgr_pkg::REG_ROWS:    rows_r    <= cfg_wdata[tcgr_pkg::DIM_W-1:0];
          tcgr_pkg::REG_FG:      fg_r      <= cfg_wdata;
          tcgr_pkg::REG_BG:      bg_r      <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      glyph_base_r <= AW'(code) * ROWS_A;
      base_y_r     <= tcgr_pkg::PY_W'(row_r) * ROWS_Y;
      base_x_r     <= {col_r, 3'b000};
    end
    if (ram_re) rd_row_r <= rd_py_r;
    if (load) begin
      out_px_r   <= base_x_r;
      out_py_r   <= base_y_r + tcgr_pkg::PY_W'(rd_row_r);
      out_bits_r <= ram_rdata;
      out_fg_r   <= fg_r;
      out_bg_r   <= bg_r;
      out_last_r <= (rd_row_r == LAST_ROW);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_bg_r, out_fg_r, out_bits_r, out_py_r, out_px_r};

endmodule

>>> hw/rtl/tcgr_checker.sv
`include "text_console_glyph_renderer_assert.svh"

module tcgr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [tcgr_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tcgr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  // stalled word stays valid and unchanged
  `TCGR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out word dropped while stalled")
  `TCGR_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "out word changed while stalled")

  // font loads and homing never hold off the next word
  `TCGR_ASSERT_NEXT(a_load_home_ready, in_tvalid && in_tready && in_tuser != tcgr_pkg::FUNC_PUT, in_tready, "busy after a non-drawing command")

  // an idle block stays ready
  `TCGR_ASSERT_NEXT(a_idle_ready, in_tready && !in_tvalid, in_tready, "ready dropped with no word taken")

  // glyph rows start on a character cell boundary
  `TCGR_ASSERT_NOW(a_cell_align, out_tvalid, out_tdata[2:0] == 3'b000, "pixel_x off cell boundary")

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/sv/tb_text_console_glyph_renderer.sv
`timescale 1ns / 100ps

module tb_text_console_glyph_renderer;
  import tcgr_pkg::*;

  localparam logic [IN_TUSER_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STORE_BYTES    = GLYPH_COUNT_DEF * GLYPH_ROWS_DEF;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_SETTLE   = 24;
  localparam int END_SETTLE     = 40;

  typedef struct packed {
    logic [PX_W-1:0]    pixel_x;
    logic [PY_W-1:0]    pixel_y;
    logic [7:0]         row_bits;
    logic [COLOR_W-1:0] fore_color;
    logic [COLOR_W-1:0] back_color;
    logic               last_row;
  } glyph_row_t;

  class glyph_row_predictor;
    logic [DIM_W-1:0]   columns_reg;
    logic [DIM_W-1:0]   rows_reg;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    int unsigned        cur_col;
    int unsigned        cur_row;
    logic [7:0]         font [STORE_BYTES];
    glyph_row_t         rows_due [$];
    int unsigned        mismatches;

    function new();
      columns_reg = COLUMNS_RESET;
      rows_reg    = ROWS_RESET;
      fg_reg      = FG_RESET;
      bg_reg      = BG_RESET;
      cur_col     = 0;
      cur_row     = 0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_COLUMNS: columns_reg = val[DIM_W-1:0];
        REG_ROWS:    rows_reg = val[DIM_W-1:0];
        REG_FG:      fg_reg = val;
        REG_BG:      bg_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned screen_dim(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > 9'd256) return 256;
      return {23'b0, v};
    endfunction

    // cursor update and glyph rows for one accepted command word
    function void note_command(logic [IN_TUSER_W-1:0] fn, logic [7:0] code,
                               logic [10:0] addr, logic [7:0] fb);
      int unsigned cols;
      int unsigned rows;
      int unsigned col;
      int unsigned row;
      glyph_row_t  r;
      cols = screen_dim(columns_reg);
      rows = screen_dim(rows_reg);
      col  = cur_col;
      row  = cur_row;
      case (fn)
        FUNC_LOAD: font[addr] = fb;
        FUNC_HOME: begin
          cur_col = 0;
          cur_row = 0;
        end
        FUNC_PUT: begin
          if (code == CHAR_NL) begin
            col = 0;
            row++;
          end else if (code == CHAR_CR) begin
            col = 0;
          end else if (code == CHAR_TAB) begin
            col = (col + 4) & ~32'd3;
          end else begin
            if (code < GLYPH_COUNT_DEF) begin
              for (int py = 0; py < GLYPH_ROWS_DEF; py++) begin
                r.pixel_x    = PX_W'(col * GLYPH_COLS);
                r.pixel_y    = PY_W'(row * GLYPH_ROWS_DEF + py);
                r.row_bits   = font[code * GLYPH_ROWS_DEF + py];
                r.fore_color = fg_reg;
                r.back_color = bg_reg;
                r.last_row   = (py == GLYPH_ROWS_DEF - 1);
                rows_due.push_back(r);
              end
            end
            col++;
          end
          if (col >= cols) begin
            col = 0;
            row++;
          end
          if (row >= rows) row = rows - 1;
          cur_col = col & 8'hFF;
          cur_row = row & 8'hFF;
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [COLOR_W-1:0] e, logic [COLOR_W-1:0] a);
      if (e !== a) begin
        $display("%0t: %s expected 'h%0h actual 'h%0h", $time, name, e, a);
        mismatches++;
      end
    endfunction

    function void check_row(logic [OUT_TDATA_W-1:0] word, logic tlast);
      glyph_row_t e;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected word expected none actual 'h%0h", $time, word);
        mismatches++;
        return;
      end
      e = rows_due.pop_front();
      cmp_field("pixel_x", COLOR_W'(e.pixel_x), COLOR_W'(word[10:0]));
      cmp_field("pixel_y", COLOR_W'(e.pixel_y), COLOR_W'(word[22:11]));
      cmp_field("row_bits", COLOR_W'(e.row_bits), COLOR_W'(word[30:23]));
      cmp_field("fore_color", e.fore_color, word[62:31]);
      cmp_field("back_color", e.back_color, word[94:63]);
      cmp_field("last_row", COLOR_W'(e.last_row), COLOR_W'(tlast));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  glyph_row_predictor glyph_model;
  bit                 row_loaded [STORE_BYTES];
  bit                 glyph_listed [GLYPH_COUNT_DEF];
  logic [7:0]         ready_codes [$];
  int                 hold_ask;
  int                 burst_left;
  bit                 sender_steady;
  int                 idle_cycles;

  text_console_glyph_renderer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      glyph_model.note_command(in_tuser, in_tdata[7:0], in_tdata[18:8], in_tdata[26:19]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) glyph_model.check_row(out_tdata, out_tlast);
  end

  // receiver stall pattern, with an occasional long hold-off
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  int rx_tick = 0;
  always @(posedge clk) begin
    rx_tick++;
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (rx_tick % 4 == 0);
        default: out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic pace();
    int gap;
    if (!sender_steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(1, 10);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic send_word(input logic [IN_TUSER_W-1:0] fn, input logic [7:0] code,
                           input logic [10:0] addr, input logic [7:0] fb);
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {5'b0, fb, addr, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pace();
  endtask

  task automatic put_char(input logic [7:0] code);
    send_word(FUNC_PUT, code, 11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
  endtask

  function automatic bit glyph_ready(logic [6:0] g);
    for (int k = 0; k < GLYPH_ROWS_DEF; k++)
      if (!row_loaded[g * GLYPH_ROWS_DEF + k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic load_row(input logic [10:0] addr, input logic [7:0] fb);
    logic [6:0] g;
    g = addr[10:4];
    send_word(FUNC_LOAD, 8'($urandom_range(0, 255)), addr, fb);
    row_loaded[addr] = 1'b1;
    if (!glyph_listed[g] && glyph_ready(g)) begin
      glyph_listed[g] = 1'b1;
      ready_codes.push_back({1'b0, g});
    end
  endtask

  function automatic logic [7:0] ready_glyph();
    return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
  endfunction

  function automatic bit is_control(logic [7:0] code);
    return code == CHAR_TAB || code == CHAR_NL || code == CHAR_CR;
  endfunction

  // drawn codes are only glyphs whose rows have all been loaded
  function automatic logic [7:0] pick_code(bit tab_heavy);
    int r;
    int ctrl_hi;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    ctrl_hi = tab_heavy ? 80 : 62;
    if (r < 45) begin
      code = ready_glyph();
    end else if (r < ctrl_hi) begin
      if (tab_heavy && $urandom_range(0, 4) != 0) code = CHAR_TAB;
      else begin
        case ($urandom_range(0, 2))
          0: code = CHAR_TAB;
          1: code = CHAR_NL;
          default: code = CHAR_CR;
        endcase
      end
    end else if (r < ctrl_hi + 15) begin
      code = 8'($urandom_range(128, 255));
    end else begin
      code = 8'($urandom_range(0, 255));
      if (code < GLYPH_COUNT_DEF && !is_control(code) && !glyph_ready(code[6:0]))
        code = ready_glyph();
    end
    return code;
  endfunction

  task automatic run_phase(input int count, input bit tab_heavy);
    int n;
    int r;
    logic [6:0] g;
    n = 0;
    burst_left = $urandom_range(1, 16);
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        put_char(pick_code(tab_heavy));
        n++;
      end else if (r < 72) begin
        load_row(11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
        n++;
      end else if (r < 78) begin
        g = 7'($urandom_range(0, GLYPH_COUNT_DEF - 1));
        for (int k = 0; k < GLYPH_ROWS_DEF; k++)
          load_row({g, 4'(k)}, 8'($urandom_range(0, 255)));
        n += GLYPH_ROWS_DEF;
      end else if (r < 86) begin
        send_word(FUNC_HOME, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
                  8'($urandom_range(0, 255)));
        n++;
      end else if (r < 90) begin
        send_word(FUNC_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
                  8'($urandom_range(0, 255)));
      end else begin
        put_char(ready_glyph());
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (glyph_model.rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic write_screen(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows,
                              input logic [CFG_DATA_W-1:0] fg, input logic [CFG_DATA_W-1:0] bg);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_ADDR_W-1:0] idx [4];
    vals = '{cols, rows, fg, bg};
    idx  = '{REG_COLUMNS, REG_ROWS, REG_FG, REG_BG};
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_addr  <= idx[i];
      cfg_wdata <= vals[i];
      glyph_model.set_reg(idx[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sender_steady = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = FUNC_PUT;
    cfg_we        = 1'b0;
    cfg_addr      = REG_COLUMNS;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    hold_ask      = 0;
    burst_left    = 1;
    sender_steady = 1'b0;
    glyph_model   = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fonts for the first and last glyph
    for (int k = 0; k < GLYPH_ROWS_DEF; k++)
      load_row(11'(k), (k == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
    for (int k = 0; k < GLYPH_ROWS_DEF; k++)
      load_row(11'((GLYPH_COUNT_DEF - 1) * GLYPH_ROWS_DEF + k), k[0] ? 8'hFF : 8'h00);

    put_char(8'd0);
    put_char(8'd127);
    put_char(CHAR_TAB);
    put_char(8'd0);
    put_char(CHAR_NL);
    put_char(8'd127);
    put_char(CHAR_CR);
    put_char(8'd128);
    put_char(8'd255);
    send_word(FUNC_UNUSED, 8'hFF, 11'h7FF, 8'hFF);
    put_char(CHAR_TAB);
    put_char(CHAR_TAB);
    put_char(CHAR_TAB);
    send_word(FUNC_HOME, 8'h00, 11'h000, 8'h00);
    load_row(11'h7FF, 8'hA5);
    put_char(8'd127);
    load_row(11'h000, 8'h00);
    put_char(8'd0);
    put_char(CHAR_NL);
    put_char(8'd200);
    send_word(FUNC_HOME, 8'hFF, 11'h7FF, 8'hFF);
    run_phase(20, 1'b0);

    wait_drained();
    write_screen(3, 2, $urandom, $urandom);
    run_phase(40, 1'b0);

    wait_drained();
    write_screen(0, 0, 32'hFFFF_FFFF, 32'h0);
    run_phase(40, 1'b0);

    // wide screen, receiver held off while the sender keeps offering words
    wait_drained();
    write_screen(256, 256, 32'h0, 32'hFFFF_FFFF);
    sender_steady = 1'b1;
    hold_ask++;
    run_phase(40, 1'b1);

    // cursor now sits beyond the shrunk screen
    wait_drained();
    write_screen(2, 1, $urandom, 32'h0);
    run_phase(40, 1'b0);

    wait_drained();
    write_screen(511, 300, $urandom, $urandom);
    run_phase(20, 1'b0);
    wait_drained();
    run_phase(20, 1'b0);

    wait_drained();
    write_screen(1, 3, $urandom, $urandom);
    run_phase(40, 1'b0);

    wait_drained();
    write_screen($urandom_range(1, 8), $urandom_range(1, 4), $urandom, $urandom);
    run_phase(40, 1'b0);

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (glyph_model.mismatches == 0 && glyph_model.rows_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
